FILE: sv/usb_ls_data_packet_line_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// usb low-speed line encoder assertion macros
// shared concurrent assertion forms, clocked and gated by the active low reset
// ----------------------------------------------------------------------------
`ifndef USB_LS_DATA_PACKET_LINE_ENCODER_UNIT_ASSERT_SVH
`define USB_LS_DATA_PACKET_LINE_ENCODER_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define USBLS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define USBLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/usbls_pkg.sv
// ----------------------------------------------------------------------------
// usbls_pkg
// types, line state codes, tables and crc helper for the usb low-speed encoder
// ----------------------------------------------------------------------------
package usbls_pkg;

    typedef logic [1:0] line_t;

    localparam line_t LS_SE0 = 2'd0;
    localparam line_t LS_J   = 2'd1;
    localparam line_t LS_K   = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);
    localparam logic [CNT_W-1:0] CRC_BITS  = CNT_W'(16);
    localparam logic [CNT_W-1:0] SYNC_LAST = CNT_W'(7);
    localparam logic [CNT_W-1:0] EOP_LAST  = CNT_W'(3);

    localparam logic [2:0]  STUFF_RUN = 3'd6;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam line_t SYNC_STATES [0:7] = '{LS_K, LS_J, LS_K, LS_J, LS_K, LS_J, LS_K, LS_K};
    localparam line_t EOP_STATES  [0:3] = '{LS_SE0, LS_SE0, LS_J, LS_J};

    // one queued byte, already in send order (lsb goes out first)
    typedef struct packed {
        logic [7:0] bits;
        logic       first;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_SYNC,
        PH_DATA,
        PH_CRC,
        PH_EOP,
        PH_PAD
    } phase_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic [15:0] c;
        c = {1'b0, crc[15:1]};
        if (b ^ crc[0]) begin
            c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // differential level to line state, 1 means K
    function automatic line_t level_state(input logic level);
        return level ? LS_K : LS_J;
    endfunction

endpackage

FILE: sv/usbls_front.sv
// ----------------------------------------------------------------------------
// usbls_front
// accepts packet bytes, puts them in send order and holds them in a short queue
// ----------------------------------------------------------------------------
module usbls_front #(
    parameter int QUEUE_DEPTH = usbls_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_value,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    output logic              head_valid,
    output usbls_pkg::item_t  head,
    input  logic              pop
);
    import usbls_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(QUEUE_DEPTH);

    item_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    item_t              in_item;
    logic               push;

    // pid goes out msb first: reverse it so the back end always shifts lsb first
    always_comb begin
        in_item.first = s_first_byte;
        in_item.last  = s_last_byte;
        for (int i = 0; i < 8; i++) begin
            in_item.bits[i] = s_first_byte ? s_byte_value[7-i] : s_byte_value[i];
        end
    end

    assign s_ready    = (count_reg != FULL_CNT);
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != '0);
    assign head       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: sv/usbls_back.sv
// ----------------------------------------------------------------------------
// usbls_back
// line state sequencer: sync, nrzi bits with stuffing, crc16, eop and pad
// ----------------------------------------------------------------------------
`include "usb_ls_data_packet_line_encoder_unit_assert.svh"

module usbls_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  usbls_pkg::item_t  head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output usbls_pkg::line_t  m_line_state,
    output logic              m_run_end
);
    import usbls_pkg::*;

    phase_t             phase_reg, phase_next, cur_phase;
    logic [CNT_W-1:0]   cnt_reg, cnt_next, cnt_inc, bit_limit;
    logic               level_reg, level_next, level_bit;
    logic [2:0]         ones_reg, ones_next, ones_inc;
    logic [15:0]        crc_reg, crc_next;
    logic               par_reg, par_next;
    logic               stuff_reg, stuff_next;
    logic               bit_val, bits_done, out_free, emit, run_end_now;
    line_t              ls_now;
    logic               m_valid_reg, m_valid_next;
    line_t              m_line_state_reg;
    logic               m_run_end_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign cur_phase = (phase_reg == PH_START) ? (head.first ? PH_SYNC : PH_DATA) : phase_reg;
    assign bit_limit = (cur_phase == PH_CRC) ? CRC_BITS : BYTE_BITS;
    assign bit_val   = (cur_phase == PH_CRC) ? ~crc_reg[0] : head.bits[cnt_reg[2:0]];
    assign cnt_inc   = cnt_reg + 1'b1;
    assign ones_inc  = ones_reg + 1'b1;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        level_next  = level_reg;
        ones_next   = ones_reg;
        crc_next    = crc_reg;
        par_next    = par_reg;
        stuff_next  = stuff_reg;
        level_bit   = level_reg;
        bits_done   = 1'b0;
        pop         = 1'b0;
        emit        = 1'b0;
        run_end_now = 1'b0;
        ls_now      = LS_SE0;
        if (head_valid && out_free) begin
            emit = 1'b1;
            case (cur_phase)
                PH_SYNC: begin
                    ls_now     = SYNC_STATES[cnt_reg[2:0]];
                    ones_next  = '0;
                    crc_next   = CRC_INIT;
                    par_next   = 1'b0;
                    level_next = 1'b1;
                    phase_next = PH_SYNC;
                    cnt_next   = cnt_inc;
                    if (cnt_reg == SYNC_LAST) begin
                        phase_next = PH_DATA;
                        cnt_next   = '0;
                    end
                end
                PH_DATA, PH_CRC: begin
                    phase_next = cur_phase;
                    par_next   = ~par_reg;
                    if (stuff_reg) begin
                        // stuffed zero after six ones
                        level_bit  = ~level_reg;
                        ones_next  = '0;
                        stuff_next = 1'b0;
                        bits_done  = (cnt_reg == bit_limit);
                    end else begin
                        if (cur_phase == PH_CRC) begin
                            crc_next = {1'b0, crc_reg[15:1]};
                        end else if (!head.first) begin
                            crc_next = crc_step(crc_reg, bit_val);
                        end
                        if (bit_val) begin
                            if (ones_inc == STUFF_RUN) begin
                                ones_next  = '0;
                                stuff_next = 1'b1;
                            end else begin
                                ones_next = ones_inc;
                            end
                        end else begin
                            level_bit = ~level_reg;
                            ones_next = '0;
                        end
                        cnt_next  = cnt_inc;
                        bits_done = (cnt_inc == bit_limit) &&
                                    !(bit_val && (ones_inc == STUFF_RUN));
                    end
                    ls_now     = level_state(level_bit);
                    level_next = level_bit;
                    if (bits_done) begin
                        cnt_next = '0;
                        if (cur_phase == PH_CRC) begin
                            // line goes idle (J) after the packet
                            phase_next = PH_EOP;
                            level_next = 1'b0;
                            ones_next  = '0;
                            crc_next   = CRC_INIT;
                        end else if (head.last) begin
                            phase_next = PH_CRC;
                        end else begin
                            phase_next  = PH_START;
                            pop         = 1'b1;
                            run_end_now = 1'b1;
                        end
                    end
                end
                PH_EOP: begin
                    ls_now     = EOP_STATES[cnt_reg[1:0]];
                    phase_next = PH_EOP;
                    cnt_next   = cnt_inc;
                    if (cnt_reg == EOP_LAST) begin
                        cnt_next = '0;
                        if (par_reg) begin
                            phase_next = PH_PAD;
                        end else begin
                            phase_next  = PH_START;
                            pop         = 1'b1;
                            run_end_now = 1'b1;
                        end
                    end
                end
                PH_PAD: begin
                    ls_now      = LS_J;
                    par_next    = 1'b0;
                    phase_next  = PH_START;
                    pop         = 1'b1;
                    run_end_now = 1'b1;
                end
                default: begin
                    emit       = 1'b0;
                    phase_next = PH_START;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_START;
            cnt_reg     <= '0;
            level_reg   <= 1'b1;
            ones_reg    <= '0;
            crc_reg     <= CRC_INIT;
            par_reg     <= 1'b0;
            stuff_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            level_reg   <= level_next;
            ones_reg    <= ones_next;
            crc_reg     <= crc_next;
            par_reg     <= par_next;
            stuff_reg   <= stuff_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_line_state_reg <= ls_now;
            m_run_end_reg    <= run_end_now;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_state = m_line_state_reg;
    assign m_run_end    = m_run_end_reg;

    `USBLS_ASSERT_NOW(a_pop_marks_end, aclk, aresetn, pop, emit && run_end_now && head_valid, "queue pop without a final line state")
    `USBLS_ASSERT_NOW(a_stuff_clears_run, aclk, aresetn, stuff_reg, ones_reg == 3'd0 && (phase_reg == PH_DATA || phase_reg == PH_CRC), "stuff pending outside bit phases")
    `USBLS_ASSERT_NEXT(a_idle_after_eop, aclk, aresetn, emit && cur_phase == PH_CRC && bits_done, phase_reg == PH_EOP && !level_reg && crc_reg == CRC_INIT, "line not idle after crc")
    `USBLS_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, $stable(phase_reg) && $stable(cnt_reg) && $stable(crc_reg), "sequencer moved while stalled")

endmodule

FILE: sv/usb_ls_data_packet_line_encoder_unit.sv
// ----------------------------------------------------------------------------
// usb_ls_data_packet_line_encoder_unit
// usb low-speed data packet to D+/D- line state encoder (nrzi, bit stuffing)
// ----------------------------------------------------------------------------
// usage
//   input channel (s_*): one packet byte per transaction; s_first_byte starts a
//   packet (sync K J K J K J K K, then the byte as pid, msb first), later bytes
//   go out lsb first and feed a crc16; s_last_byte appends the inverted crc,
//   eop (SE0 SE0 J J) and a J pad when the packet's bit state count is odd
//   result channel (m_*): one line state per transaction, m_run_end high on
//   the last state caused by an input byte
//   when the sequencer is idle, an accepted byte is first registered in the
//   queue and its first line state is then registered in the output register
//   throughput: one line state per cycle while the receiver is ready and a
//   byte is queued; the output register, which emits one state a cycle,
//   sets this figure
//   a small byte queue lets the next byte be taken while states still flow
//   reset: line level K, crc all ones, queue and output register empty
//   receiver stall: the output register holds, the sequencer waits, and
//   s_ready drops once the queue is full
// ----------------------------------------------------------------------------
module usb_ls_data_packet_line_encoder_unit #(
    parameter int QUEUE_DEPTH = usbls_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    // byte transactions
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_byte_value,
    input  logic              s_first_byte,
    input  logic              s_last_byte,
    // line state transactions
    output logic              m_valid,
    input  logic              m_ready,
    output usbls_pkg::line_t  m_line_state,
    output logic              m_run_end
);
    import usbls_pkg::*;

    // queue head towards the sequencer
    item_t head;
    logic  head_valid;
    logic  pop;

    // front: byte ordering and queue
    usbls_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_value (s_byte_value),
        .s_first_byte (s_first_byte),
        .s_last_byte  (s_last_byte),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    // back: line state sequencer and output register
    usbls_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_state (m_line_state),
        .m_run_end    (m_run_end)
    );

endmodule
